/* rtl/mmbd_pkg.sv */
// Shared constants and types of the mip chain box downsampler.
package mmbd_pkg;

    localparam int MAX_WIDTH  = 2048;
    localparam int MAX_LEVELS = 12;
    localparam int NUM_RES    = MAX_LEVELS - 1;
    localparam int ADDR_W     = $clog2(MAX_WIDTH / 2);
    localparam int CNT_W      = $clog2(MAX_WIDTH);
    localparam int SUM_W      = 36;

    localparam logic [1:0] REG_IMAGE_WIDTH  = 2'd0;
    localparam logic [1:0] REG_IMAGE_HEIGHT = 2'd1;
    localparam logic [1:0] REG_LEVEL_COUNT  = 2'd2;

    typedef struct packed {
        logic        valid;
        logic [9:0]  column;
        logic [9:0]  row;
        logic [31:0] pix;
    } res_t;

    typedef struct packed {
        logic                      pix_valid;
        logic [31:0]               pix;
        res_t [NUM_RES-1:0]        res;
    } bundle_t;

    typedef struct packed {
        logic              we;
        logic [ADDR_W-1:0] waddr;
        logic [SUM_W-1:0]  wdata;
        logic [ADDR_W-1:0] raddr;
    } ram_req_t;

endpackage

/* rtl/mmbd_ram.sv */
// Single write port, single registered read port memory with write-first bypass.
module mmbd_ram #(
    parameter int DEPTH  = 1024,
    parameter int DATA_W = 36,
    parameter int AW     = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              aclk,
    input  logic              we,
    input  logic [AW-1:0]     waddr,
    input  logic [DATA_W-1:0] wdata,
    input  logic [AW-1:0]     raddr,
    output logic [DATA_W-1:0] rdata
);

    logic [DATA_W-1:0] mem [DEPTH];
    logic [DATA_W-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (we && (waddr == raddr)) begin
            rdata_reg <= wdata;
        end else begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

/* rtl/mmbd_cell.sv */
// One mip level: position counters, held left pixel and 2x2 averaging.
module mmbd_cell (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     en,
    input  logic [3:0]               cell_level,
    input  logic [3:0]               levels,
    input  logic [11:0]              w0,
    input  logic [11:0]              h0,
    input  mmbd_pkg::bundle_t        in_bundle,
    output mmbd_pkg::bundle_t        out_bundle,
    output mmbd_pkg::ram_req_t       ram_req,
    input  logic [mmbd_pkg::SUM_W-1:0] rd_data
);

    logic [mmbd_pkg::CNT_W-1:0] x_reg, x_next, y_reg, y_next;
    logic [31:0]                held_reg, held_next;
    mmbd_pkg::bundle_t          out_reg, out_next;
    logic [11:0]                wk, hk, x_inc, y_inc;
    logic                       adv, deriving;
    logic [8:0]                 sum [4];
    logic [9:0]                 tot [4];
    logic [mmbd_pkg::SUM_W-1:0] wdata;
    logic [31:0]                avg;

    always_comb begin
        wk    = w0 >> cell_level;
        hk    = h0 >> cell_level;
        x_inc = {1'b0, x_reg} + 12'd1;
        y_inc = {1'b0, y_reg} + 12'd1;
        adv   = en && in_bundle.pix_valid;
        x_next = x_reg;
        y_next = y_reg;
        if (adv) begin
            if (x_inc >= wk) begin
                x_next = '0;
                y_next = (y_inc >= hk) ? '0 : y_inc[mmbd_pkg::CNT_W-1:0];
            end else begin
                x_next = x_inc[mmbd_pkg::CNT_W-1:0];
            end
        end
        deriving = in_bundle.pix_valid
            && (({1'b0, cell_level} + 5'd1) < {1'b0, levels})
            && ({1'b0, x_reg} < (wk & ~12'd1))
            && ({1'b0, y_reg} < (hk & ~12'd1));
        for (int i = 0; i < 4; i++) begin
            sum[i] = {1'b0, held_reg[8*i +: 8]} + {1'b0, in_bundle.pix[8*i +: 8]};
            tot[i] = {1'b0, rd_data[9*i +: 9]} + {1'b0, sum[i]};
            wdata[9*i +: 9] = sum[i];
            avg[8*i +: 8]   = tot[i][9:2];
        end
        held_next = held_reg;
        if (adv && deriving && !x_reg[0]) begin
            held_next = in_bundle.pix;
        end
        out_next = in_bundle;
        out_next.pix_valid = 1'b0;
        out_next.pix = avg;
        if (in_bundle.pix_valid && (cell_level != 4'd0)) begin
            out_next.res[cell_level - 4'd1] = '{valid: 1'b1, column: x_reg[9:0],
                                                row: y_reg[9:0], pix: in_bundle.pix};
        end
        if (deriving && x_reg[0] && y_reg[0]) begin
            out_next.pix_valid = 1'b1;
        end
        ram_req.we    = adv && deriving && x_reg[0] && !y_reg[0];
        ram_req.waddr = x_reg[mmbd_pkg::CNT_W-1:1];
        ram_req.wdata = wdata;
        ram_req.raddr = x_next[mmbd_pkg::CNT_W-1:1];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            x_reg   <= '0;
            y_reg   <= '0;
            out_reg <= '0;
        end else begin
            x_reg <= x_next;
            y_reg <= y_next;
            if (en) begin
                out_reg <= out_next;
            end
        end
        held_reg <= held_next;
    end

    assign out_bundle = out_reg;

endmodule

/* rtl/mmbd_emit.sv */
// Output stage that sends the results of one input pixel beat by beat in level order.
module mmbd_emit (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  mmbd_pkg::res_t [mmbd_pkg::NUM_RES-1:0] tail_res,
    output logic                                  en,
    output logic                                  m_tvalid,
    input  logic                                  m_tready,
    output logic [55:0]                           m_tdata,  // level, column, row, r, g, b, a
    output logic                                  m_tlast
);

    mmbd_pkg::res_t [mmbd_pkg::NUM_RES-1:0] slots_reg;
    logic                                   busy_reg;
    logic [3:0]                             sel;
    logic                                   found, others, tail_any, fire;
    mmbd_pkg::res_t                         cur;

    always_comb begin
        sel      = '0;
        found    = 1'b0;
        others   = 1'b0;
        tail_any = 1'b0;
        for (int i = 0; i < mmbd_pkg::NUM_RES; i++) begin
            if (slots_reg[i].valid) begin
                if (found) begin
                    others = 1'b1;
                end else begin
                    found = 1'b1;
                    sel   = 4'(i);
                end
            end
            if (tail_res[i].valid) begin
                tail_any = 1'b1;
            end
        end
        cur      = slots_reg[sel];
        m_tvalid = busy_reg;
        m_tlast  = !others;
        m_tdata  = {cur.pix[31:24], cur.pix[23:16], cur.pix[15:8], cur.pix[7:0],
                    cur.row, cur.column, sel + 4'd1};
        fire     = busy_reg && m_tready;
        en       = !tail_any || !busy_reg || (m_tready && !others);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg  <= 1'b0;
            slots_reg <= '0;
        end else if (en && tail_any) begin
            busy_reg  <= 1'b1;
            slots_reg <= tail_res;
        end else if (fire) begin
            busy_reg             <= others;
            slots_reg[sel].valid <= 1'b0;
        end
    end

endmodule

/* rtl/mipmap_box_downsampler.sv */
// Top level of the streaming 2x2 box filter mip chain generator.
// Accepts one level-0 pixel per cycle unless stalled; each level is a cell of a 12-cell chain.
// Results pass through the register of every cell and then the output stage's slot register.
// Results of one pixel leave one per beat; input stalls only while those are pending.
// Reset (aresetn low, synchronous) clears counters and valid flags; row stores need none.
module mipmap_box_downsampler (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // red, green, blue, alpha
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [55:0] m_tdata,   // level, column, row, out_red, out_green, out_blue, out_alpha
    output logic        m_tlast,   // last
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [11:0] cfg_data
);

    localparam int L = mmbd_pkg::MAX_LEVELS;

    logic [11:0] width_reg, height_reg, w0, h0;
    logic [3:0]  levels_reg, levels;
    logic        en;
    mmbd_pkg::bundle_t  link [L+1];
    mmbd_pkg::ram_req_t req  [L];
    logic [mmbd_pkg::SUM_W-1:0] rdat [L];

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg  <= 12'd2048;
            height_reg <= 12'd2048;
            levels_reg <= 4'd12;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                mmbd_pkg::REG_IMAGE_WIDTH:  width_reg  <= cfg_data;
                mmbd_pkg::REG_IMAGE_HEIGHT: height_reg <= cfg_data;
                mmbd_pkg::REG_LEVEL_COUNT:  levels_reg <= cfg_data[3:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        w0 = (width_reg > 12'(mmbd_pkg::MAX_WIDTH)) ? 12'(mmbd_pkg::MAX_WIDTH) : width_reg;
        h0 = (height_reg > 12'd2048) ? 12'd2048 : height_reg;
        levels = levels_reg;
        if (levels == 4'd0) begin
            levels = 4'd1;
        end else if (levels > 4'(L)) begin
            levels = 4'(L);
        end
        link[0] = '0;
        link[0].pix_valid = s_tvalid && en;
        link[0].pix = s_tdata;
    end

    assign s_tready = en;

    for (genvar k = 0; k < L; k++) begin : g_cell
        mmbd_cell u_cell (
            .aclk       (aclk),
            .aresetn    (aresetn),
            .en         (en),
            .cell_level (4'(k)),
            .levels     (levels),
            .w0         (w0),
            .h0         (h0),
            .in_bundle  (link[k]),
            .out_bundle (link[k+1]),
            .ram_req    (req[k]),
            .rd_data    (rdat[k])
        );
        if (k < L - 1) begin : g_ram
            localparam int DEPTH = mmbd_pkg::MAX_WIDTH >> (k + 1);
            localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
            mmbd_ram #(
                .DEPTH  (DEPTH),
                .DATA_W (mmbd_pkg::SUM_W),
                .AW     (AW)
            ) u_ram (
                .aclk  (aclk),
                .we    (req[k].we),
                .waddr (req[k].waddr[AW-1:0]),
                .wdata (req[k].wdata),
                .raddr (req[k].raddr[AW-1:0]),
                .rdata (rdat[k])
            );
        end else begin : g_noram
            assign rdat[k] = '0;
        end
    end

    mmbd_emit u_emit (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .tail_res (link[L].res),
        .en       (en),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    a_reset_quiet: assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("result valid right after reset");
    a_run_continues: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tready && !m_tlast |=> m_tvalid)
        else $error("results of one pixel cut short");
    a_level_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[3:0] != 4'd0)
        else $error("result carries level zero");
    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready && !m_tlast |=> !s_tready || !m_tvalid || m_tlast || $stable(m_tdata))
        else $error("pending result changed while stalled");

endmodule
